// ===== rtl/srsh_pkg.sv =====
// Shared types and constants for the sparse register store hash block.
package srsh_pkg;

    localparam int unsigned CAPACITY_DEF        = 4096;
    localparam int unsigned WORDS_PER_ENTRY_DEF = 16;
    localparam int unsigned DATA_W              = 64;
    localparam int unsigned UNIT_W              = 4;
    localparam int unsigned ADDR_W              = 32;
    localparam int unsigned WIDX_W              = 4;
    localparam int unsigned KEY_W               = UNIT_W + 2 * ADDR_W;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_HEAD  = 14'b00000000000100,
        S_PICK  = 14'b00000000001000,
        S_FETCH = 14'b00000000010000,
        S_COMP  = 14'b00000000100000,
        S_ALLOC = 14'b00000001000000,
        S_ZBASE = 14'b00000010000000,
        S_ZERO  = 14'b00000100000000,
        S_ADDR  = 14'b00001000000000,
        S_DRD   = 14'b00010000000000,
        S_DWAIT = 14'b00100000000000,
        S_DWR   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

endpackage

// ===== rtl/sparse_register_store_hash.sv =====
// Sparse word store: chained hash table walked by a small sequencer.
//
// Input channel (i_in_valid / o_in_stall) takes one access: operation, key
// (unit, addr_ext, addr), word_index and write_data. The block is busy from
// the accepted beat until its result beat is taken, and raises o_in_stall
// all that time. Output channel (o_out_valid / i_out_stall) gives one beat
// per access: read_data, found, table_full; the beat holds while stalled.
// Sequence: S_HEAD and S_PICK fetch the chain head, then each chain entry
// is fetched (S_FETCH) and compared (S_COMP) over the single key compare
// unit; a miss ends in S_FETCH on the null entry. An in-range word is then
// read (S_ADDR, S_DRD, S_DWAIT) or written (S_ADDR, S_DWR) through the
// shared index multiplier. A write to a new key first allocates the entry
// (S_ALLOC) and zeroes every word of it (S_ZBASE, S_ZERO). The result is
// held in S_OUT until taken; the block then returns to S_IDLE and takes
// the next beat there.
// CAPACITY must be a power of two; the slot is the low address bits.
// After reset the head table is swept to empty, one slot a cycle;
// o_in_stall stays high during the sweep.
module sparse_register_store_hash
    import srsh_pkg::*;
#(
    parameter int unsigned CAPACITY        = CAPACITY_DEF,
    parameter int unsigned WORDS_PER_ENTRY = WORDS_PER_ENTRY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_operation,
    input  logic [UNIT_W-1:0] i_unit,
    input  logic [ADDR_W-1:0] i_addr_ext,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDX_W-1:0] i_word_index,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_found,
    output logic              o_table_full
);

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned FW = IW + 1;
    localparam int unsigned DW = $clog2(CAPACITY * WORDS_PER_ENTRY);
    localparam int unsigned CW = $clog2(WORDS_PER_ENTRY + 1) + 1;

    logic [IW-1:0]    head_mem [CAPACITY];
    logic [IW-1:0]    next_mem [CAPACITY];
    logic [KEY_W-1:0] key_mem  [CAPACITY];
    logic [DATA_W-1:0] data_mem [CAPACITY * WORDS_PER_ENTRY];

    t_state            r_state, n_state;
    logic [IW-1:0]     r_clr, n_clr;
    logic [FW-1:0]     r_free, n_free;
    logic [IW-1:0]     r_ent, n_ent;
    logic [IW-1:0]     r_head_val, n_head_val;
    logic [DW-1:0]     r_daddr, n_daddr;
    logic [DW-1:0]     r_zaddr, n_zaddr;
    logic [CW-1:0]     r_zcnt, n_zcnt;
    logic              r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [IW-1:0]     r_slot, n_slot;
    logic [WIDX_W-1:0] r_word, n_word;
    logic [DATA_W-1:0] r_wdata, n_wdata;
    logic [DATA_W-1:0] r_rdata, n_rdata;
    logic              r_found, n_found;
    logic              r_full, n_full;

    logic [IW-1:0]     r_head_rd;
    logic [IW-1:0]     r_next_rd;
    logic [KEY_W-1:0]  r_key_rd;
    logic [DATA_W-1:0] r_data_rd;

    logic              head_we;
    logic [IW-1:0]     head_wa;
    logic [IW-1:0]     head_wd;
    logic              data_we;
    logic [DW-1:0]     data_wa;
    logic [DATA_W-1:0] data_wd;
    logic [DW-1:0]     prod;
    logic              w_ok;
    logic              in_acc;

    assign prod   = DW'(r_ent) * DW'(WORDS_PER_ENTRY);
    assign w_ok   = {{CW{1'b0}}, r_word} < (CW + WIDX_W)'(WORDS_PER_ENTRY);
    assign in_acc = i_in_valid && !o_in_stall;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_read_data  = r_rdata;
    assign o_found      = r_found;
    assign o_table_full = r_full;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_free     = r_free;
        n_ent      = r_ent;
        n_head_val = r_head_val;
        n_daddr    = r_daddr;
        n_zaddr    = r_zaddr;
        n_zcnt     = r_zcnt;
        n_op       = r_op;
        n_key      = r_key;
        n_slot     = r_slot;
        n_word     = r_word;
        n_wdata    = r_wdata;
        n_rdata    = r_rdata;
        n_found    = r_found;
        n_full     = r_full;
        head_we    = 1'b0;
        head_wa    = r_slot;
        head_wd    = r_free[IW-1:0];
        data_we    = 1'b0;
        data_wa    = r_daddr;
        data_wd    = r_wdata;
        case (r_state)
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                head_wd = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == IW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = i_operation;
                    n_key   = {i_unit, i_addr_ext, i_addr};
                    n_slot  = i_addr[IW-1:0];
                    n_word  = i_word_index;
                    n_wdata = i_write_data;
                    n_rdata = '0;
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: n_state = S_PICK;
            S_PICK: begin
                n_ent      = r_head_rd;
                n_head_val = r_head_rd;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                if (r_ent == '0) begin
                    // miss: allocate on write when room is left
                    if (r_op == OP_WRITE) begin
                        if (r_free < FW'(CAPACITY)) begin
                            n_state = S_ALLOC;
                        end else begin
                            n_full  = 1'b1;
                            n_state = S_OUT;
                        end
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                if (r_key_rd == r_key) begin
                    n_found = 1'b1;
                    n_state = w_ok ? S_ADDR : S_OUT;
                end else begin
                    n_ent   = r_next_rd;
                    n_state = S_FETCH;
                end
            end
            S_ALLOC: begin
                head_we = 1'b1;
                n_ent   = r_free[IW-1:0];
                n_free  = r_free + 1'b1;
                n_state = S_ZBASE;
            end
            S_ZBASE: begin
                n_zaddr = prod;
                n_zcnt  = '0;
                n_state = S_ZERO;
            end
            S_ZERO: begin
                // wipe every word of the fresh entry
                data_we = 1'b1;
                data_wa = r_zaddr;
                data_wd = '0;
                n_zaddr = r_zaddr + 1'b1;
                n_zcnt  = r_zcnt + 1'b1;
                if (r_zcnt == CW'(WORDS_PER_ENTRY - 1)) begin
                    n_state = w_ok ? S_ADDR : S_OUT;
                end
            end
            S_ADDR: begin
                n_daddr = prod + DW'(r_word);
                n_state = (r_op == OP_WRITE) ? S_DWR : S_DRD;
            end
            S_DRD: n_state = S_DWAIT;
            S_DWAIT: begin
                n_rdata = r_data_rd;
                n_state = S_OUT;
            end
            S_DWR: begin
                data_we = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_free  <= FW'(1);
            r_found <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_free  <= n_free;
            r_found <= n_found;
            r_full  <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent      <= n_ent;
        r_head_val <= n_head_val;
        r_daddr    <= n_daddr;
        r_zaddr    <= n_zaddr;
        r_zcnt     <= n_zcnt;
        r_op       <= n_op;
        r_key      <= n_key;
        r_slot     <= n_slot;
        r_word     <= n_word;
        r_wdata    <= n_wdata;
        r_rdata    <= n_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        r_head_rd <= head_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ALLOC) begin
            next_mem[r_free[IW-1:0]] <= r_head_val;
            key_mem[r_free[IW-1:0]]  <= r_key;
        end
        r_next_rd <= next_mem[r_ent];
        r_key_rd  <= key_mem[r_ent];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[data_wa] <= data_wd;
        end
        r_data_rd <= data_mem[r_daddr];
    end

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FW'(CAPACITY) && r_free != '0)
        else $error("free pointer out of range");

    a_free_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ALLOC) |=> $stable(r_free))
        else $error("free pointer moved outside allocation");

    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> (!o_found && r_op == OP_WRITE))
        else $error("table full flagged on hit or read");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_op == OP_WRITE) |-> (o_read_data == '0))
        else $error("read data nonzero on write");

endmodule

// ===== tb/sparse_register_store_hash_test.sv =====
// Self-checking testbench for the chained hash word store.
`timescale 1ns / 100ps

module sparse_register_store_hash_test
    import srsh_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int POOL_SIZE      = 48;

    class access_scoreboard;
        typedef struct {
            logic [DATA_W-1:0] read_data;
            logic              found;
            logic              table_full;
        } t_result;

        t_result            pending[$];
        int                 entry_of[logic [KEY_W-1:0]];
        logic [DATA_W-1:0]  words[int];
        int                 next_free = 1;
        int                 errors    = 0;
        int                 hits      = 0;
        int                 fulls     = 0;
        int                 checked   = 0;

        function void note_access(logic op, logic [UNIT_W-1:0] u, logic [ADDR_W-1:0] ext,
                                  logic [ADDR_W-1:0] a, logic [WIDX_W-1:0] w,
                                  logic [DATA_W-1:0] wd);
            logic [KEY_W-1:0] key;
            t_result          res;
            int               e;
            bit               w_ok;
            key  = {u, ext, a};
            w_ok = (w < WORDS_PER_ENTRY_DEF);
            e    = entry_of.exists(key) ? entry_of[key] : 0;
            res.read_data  = '0;
            res.found      = (e != 0);
            res.table_full = 1'b0;
            if (op == OP_READ) begin
                if (e != 0 && w_ok && words.exists(e * WORDS_PER_ENTRY_DEF + w))
                    res.read_data = words[e * WORDS_PER_ENTRY_DEF + w];
            end else begin
                if (e == 0) begin
                    if (next_free < CAPACITY_DEF) begin
                        e = next_free;
                        next_free++;
                        entry_of[key] = e;
                    end else begin
                        res.table_full = 1'b1;
                    end
                end
                if (e != 0 && w_ok)
                    words[e * WORDS_PER_ENTRY_DEF + w] = wd;
            end
            if (res.found) hits++;
            if (res.table_full) fulls++;
            pending.push_back(res);
        endfunction

        function void check_result(logic [DATA_W-1:0] rd, logic f, logic full);
            t_result exp_res;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: result beat with nothing expected (rd %h found %b full %b)",
                         $time, rd, f, full);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (rd !== exp_res.read_data) begin
                $display("%0t: read_data expected %h actual %h", $time, exp_res.read_data, rd);
                errors++;
            end
            if (f !== exp_res.found) begin
                $display("%0t: found expected %b actual %b", $time, exp_res.found, f);
                errors++;
            end
            if (full !== exp_res.table_full) begin
                $display("%0t: table_full expected %b actual %b", $time,
                         exp_res.table_full, full);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_operation = OP_READ;
    logic [UNIT_W-1:0] i_unit = '0;
    logic [ADDR_W-1:0] i_addr_ext = '0;
    logic [ADDR_W-1:0] i_addr = '0;
    logic [WIDX_W-1:0] i_word_index = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic              o_found;
    logic              o_table_full;

    access_scoreboard  store_sb;
    int                snd_idle = 0;
    int                rcv_idle = 0;
    int                hold_reqs = 0;
    int                hold_seen = 0;
    int                hold_cnt = 0;
    int                quiet_cycles = 0;
    int                sent = 0;
    logic [UNIT_W-1:0] pool_unit[POOL_SIZE];
    logic [ADDR_W-1:0] pool_ext[POOL_SIZE];
    logic [ADDR_W-1:0] pool_addr[POOL_SIZE];

    sparse_register_store_hash DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_unit       (i_unit),
        .i_addr_ext   (i_addr_ext),
        .i_addr       (i_addr),
        .i_word_index (i_word_index),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_found      (o_found),
        .o_table_full (o_table_full)
    );

    always #5 i_clk = ~i_clk;

    // Take result beats, then pick the next stall value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            store_sb.check_result(o_read_data, o_found, o_table_full);
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_cnt  <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     store_sb.pending.size());
            $display("sparse_register_store_hash_test: FAIL");
            $finish;
        end
    end

    task automatic send_access(logic op, logic [UNIT_W-1:0] u, logic [ADDR_W-1:0] ext,
                               logic [ADDR_W-1:0] a, logic [WIDX_W-1:0] w,
                               logic [DATA_W-1:0] wd);
        int gap;
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_unit       <= u;
        i_addr_ext   <= ext;
        i_addr       <= a;
        i_word_index <= w;
        i_write_data <= wd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        store_sb.note_access(op, u, ext, a, w, wd);
        sent++;
        if ($urandom_range(99) < snd_idle) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        while (store_sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_items(int count);
        int               k;
        logic [UNIT_W-1:0] u;
        logic [ADDR_W-1:0] ext;
        logic [ADDR_W-1:0] a;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                u   = UNIT_W'($urandom);
                ext = $urandom;
                a   = $urandom;
            end else begin
                k   = $urandom_range(POOL_SIZE - 1);
                u   = pool_unit[k];
                ext = pool_ext[k];
                a   = pool_addr[k];
            end
            send_access(1'($urandom_range(1)), u, ext, a, WIDX_W'($urandom),
                        {$urandom, $urandom});
        end
    endtask

    initial begin
        store_sb = new();
        // Crowd the pool onto a few slots so chains get deep.
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_unit[k] = UNIT_W'($urandom);
            pool_ext[k]  = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
            pool_addr[k] = (ADDR_W'($urandom) << 12) | ADDR_W'($urandom_range(5));
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: misses, extremes, shared slots, partial key matches.
        send_access(OP_READ,  4'h0, 32'h0, 32'h0, 4'h0, '0);
        send_access(OP_WRITE, 4'h0, 32'h0, 32'h0, 4'h0, '1);
        send_access(OP_READ,  4'h0, 32'h0, 32'h0, 4'h0, '0);
        send_access(OP_READ,  4'h0, 32'h0, 32'h0, 4'h1, '1);
        send_access(OP_WRITE, 4'hF, '1, '1, 4'hF, 64'hA5A5_5A5A_0F0F_F0F0);
        send_access(OP_READ,  4'hF, '1, '1, 4'hF, '0);
        send_access(OP_WRITE, 4'hF, '1, '1, 4'hF, '0);
        send_access(OP_READ,  4'hF, '1, '1, 4'hF, '0);
        send_access(OP_WRITE, 4'h1, 32'h1, 32'h0000_0005, 4'h3, 64'h1111);
        send_access(OP_WRITE, 4'h2, 32'h2, 32'h0000_1005, 4'h3, 64'h2222);
        send_access(OP_WRITE, 4'h3, 32'h3, 32'h0000_2005, 4'h3, 64'h3333);
        send_access(OP_READ,  4'h1, 32'h1, 32'h0000_0005, 4'h3, '0);
        send_access(OP_READ,  4'h2, 32'h2, 32'h0000_1005, 4'h3, '0);
        send_access(OP_READ,  4'h3, 32'h3, 32'h0000_2005, 4'h3, '0);
        send_access(OP_READ,  4'h2, 32'h1, 32'h0000_0005, 4'h3, '0);
        send_access(OP_READ,  4'h1, 32'h2, 32'h0000_0005, 4'h3, '0);
        send_access(OP_READ,  4'h1, 32'h1, 32'h0000_1005, 4'h3, '0);
        send_access(OP_WRITE, 4'h1, 32'h1, 32'h0000_0005, 4'h0, 64'h8000_0000_0000_0001);
        send_access(OP_READ,  4'h1, 32'h1, 32'h0000_0005, 4'h0, '0);
        send_access(OP_READ,  4'h1, 32'h1, 32'h0000_0005, 4'hF, '0);

        snd_idle = 9;
        rcv_idle = 69;
        random_items(400);
        hold_reqs <= hold_reqs + 1;
        random_items(20);
        i_in_valid <= 1'b0;
        drain_results();
        snd_idle = 69;
        rcv_idle = 9;
        random_items(400);
        snd_idle = 0;
        rcv_idle = 0;
        random_items(400);

        // Fresh keys mixed with reads of a known entry.
        for (int n = 0; n < 6; n++) begin
            send_access(OP_WRITE, UNIT_W'($urandom), $urandom, $urandom, WIDX_W'($urandom),
                        {$urandom, $urandom});
            send_access(OP_READ, 4'h1, 32'h1, 32'h0000_0005, 4'h0, '0);
        end
        send_access(OP_WRITE, 4'hF, '1, '1, 4'h7, '1);
        send_access(OP_READ,  4'hF, '1, '1, 4'h7, '0);
        i_in_valid <= 1'b0;

        drain_results();
        repeat (50) @(posedge i_clk);
        if (store_sb.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     store_sb.pending.size());
            store_sb.errors++;
        end
        $display("Covered %0d accesses: %0d key hits, %0d writes dropped on a full table.",
                 sent, store_sb.hits, store_sb.fulls);
        $display("Random traffic ran under three idle mixes plus one long output hold-off.");
        if (store_sb.errors == 0)
            $display("sparse_register_store_hash_test: PASS");
        else
            $display("sparse_register_store_hash_test: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/srsh_pkg.sv
rtl/sparse_register_store_hash.sv
tb/sparse_register_store_hash_test.sv
